// File: sv/i2p_pkg.sv
`timescale 1ns / 1ps
package i2p_pkg;

    // Character codes used by the converter.
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_LOW_A  = 8'h61;
    localparam logic [7:0] C_LOW_Z  = 8'h7A;
    localparam logic [7:0] C_NUL    = 8'h00;

    // Function names and the stack codes that stand for them.
    localparam logic [47:0] N_ARCSIN = 48'h61_72_63_73_69_6E;
    localparam logic [47:0] N_ARCCOS = 48'h61_72_63_63_6F_73;
    localparam logic [47:0] N_ARCTAN = 48'h61_72_63_74_61_6E;
    localparam logic [47:0] N_SQUARE = 48'h73_71_75_61_72_65;
    localparam logic [23:0] N_SIN    = 24'h73_69_6E;
    localparam logic [23:0] N_COS    = 24'h63_6F_73;
    localparam logic [23:0] N_TAN    = 24'h74_61_6E;
    localparam logic [7:0]  K_ARCSIN = 8'h71;
    localparam logic [7:0]  K_ARCCOS = 8'h77;
    localparam logic [7:0]  K_ARCTAN = 8'h65;
    localparam logic [7:0]  K_SQUARE = 8'h72;
    localparam logic [7:0]  K_SIN    = 8'h73;
    localparam logic [7:0]  K_COS    = 8'h63;
    localparam logic [7:0]  K_TAN    = 8'h74;

    // Error codes.
    localparam logic [1:0] E_OK       = 2'd0;
    localparam logic [1:0] E_EMPTY    = 2'd1;
    localparam logic [1:0] E_UNMATCH  = 2'd2;
    localparam logic [1:0] E_OVERFLOW = 2'd3;

    localparam logic [5:0] MAX_RESULTS = 6'd40;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic [1:0] error_code;
    } t_out_item;

    // Kind of the current character.
    typedef enum logic [2:0] {
        CL_DIGIT, CL_LETTER, CL_PUSH, CL_RPAR, CL_PM, CL_MD, CL_OTHER
    } t_cls;

    // Source of a character written to the output.
    typedef enum logic [1:0] {
        PS_SPACE, PS_CHAR, PS_TOP, PS_ZERO
    } t_src;

    typedef struct packed {
        logic capture;
        logic push;
        logic push_code;
        logic pop;
        logic drop;
        logic put;
        t_src put_sel;
        logic set_sep;
        logic name_step;
        logic name_clear;
        logic in_num_set;
        logic in_num_clr;
        logic commit;
        logic deliver;
        logic err_out;
        logic latch;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        t_cls       cls;
        logic [1:0] err;
        logic       latched;
        logic       last;
        logic       sep;
        logic       in_num;
        logic       zero_need;
        logic       cnt_zero;
        logic       top_lp;
        logic       top_pm;
        logic       name_hit;
        logic       put_rdy;
        logic       out_free;
        logic       hold_v;
    } t_sts;

    // Stack code of a function name ending the buffer, or zero.
    function automatic logic [7:0] f_match(input logic [47:0] nb, input logic [2:0] len);
        logic [7:0] code;
        code = C_NUL;
        if (len >= 3'd3) begin
            if (nb[23:0] == N_SIN) code = K_SIN;
            else if (nb[23:0] == N_COS) code = K_COS;
            else if (nb[23:0] == N_TAN) code = K_TAN;
        end
        if (len >= 3'd6) begin
            if (nb == N_ARCSIN) code = K_ARCSIN;
            else if (nb == N_ARCCOS) code = K_ARCCOS;
            else if (nb == N_ARCTAN) code = K_ARCTAN;
            else if (nb == N_SQUARE) code = K_SQUARE;
        end
        return code;
    endfunction

endpackage

// File: sv/i2p_dpath.sv
`timescale 1ns / 1ps
module i2p_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2p_pkg::t_in_item   i_data,
    input  i2p_pkg::t_cmd       i_cmd,
    output i2p_pkg::t_sts       o_sts,
    output logic                o_valid,
    output i2p_pkg::t_out_item  o_data,
    input  logic                i_stall
);
    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    r_mem [STACK_DEPTH];
    logic [7:0]    r_rd;
    logic [7:0]    r_top;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_lp;
    logic [7:0]    r_char;
    logic          r_last;
    logic [7:0]    r_prev;
    logic          r_at_start;
    logic          r_in_num;
    logic [47:0]   r_nb;
    logic [2:0]    r_nlen;
    logic          r_latched;
    logic          r_sep;
    logic [7:0]    r_hold;
    logic          r_hold_v;
    logic [5:0]    r_ocnt;
    logic          r_ovalid;
    t_out_item     r_out;

    logic [47:0]   n_nb;
    logic [2:0]    n_nlen;
    logic [7:0]    code;
    logic [7:0]    push_data;
    logic [7:0]    put_data;
    logic          full;
    logic          out_free;
    logic          room;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_cls          cls;
    logic [1:0]    err;

    // Name buffer after the current letter and the code it may complete.
    assign n_nb   = {r_nb[39:0], r_char};
    assign n_nlen = (r_nlen < 3'd6) ? r_nlen + 3'd1 : 3'd6;
    assign code   = f_match(n_nb, n_nlen);

    assign full     = (r_cnt == CW'(STACK_DEPTH));
    assign out_free = !r_ovalid || !i_stall;
    assign room     = (r_ocnt < MAX_RESULTS);
    assign rd_addr  = AW'(r_cnt - CW'(2));
    assign wr_addr  = AW'(r_cnt);
    assign push_data = i_cmd.push_code ? code : r_char;

    always_comb begin
        case (i_cmd.put_sel)
            PS_SPACE: put_data = C_SPACE;
            PS_CHAR:  put_data = r_char;
            PS_TOP:   put_data = r_top;
            PS_ZERO:  put_data = C_ZERO;
            default:  put_data = C_SPACE;
        endcase
    end

    // Classify the character and decide its error up front.
    always_comb begin
        cls = CL_OTHER;
        err = E_OK;
        if ((r_char >= C_ZERO && r_char <= C_NINE) || r_char == C_DOT) begin
            cls = CL_DIGIT;
        end else if (r_char >= C_LOW_A && r_char <= C_LOW_Z) begin
            cls = CL_LETTER;
            if (code != C_NUL && full) err = E_OVERFLOW;
        end else if (r_char == C_LPAR || r_char == C_CARET) begin
            cls = CL_PUSH;
            if (full) err = E_OVERFLOW;
        end else if (r_char == C_RPAR) begin
            cls = CL_RPAR;
            if (r_prev == C_LPAR) err = E_EMPTY;
            else if (r_lp == '0) err = E_UNMATCH;
        end else if (r_char == C_PLUS || r_char == C_MINUS) begin
            cls = CL_PM;
            if (full && r_top == C_LPAR) err = E_OVERFLOW;
        end else if (r_char == C_STAR || r_char == C_SLASH || r_char == C_PCT) begin
            cls = CL_MD;
            if (full && (r_top == C_LPAR || r_top == C_PLUS || r_top == C_MINUS))
                err = E_OVERFLOW;
        end
    end

    assign o_sts.cls       = cls;
    assign o_sts.err       = err;
    assign o_sts.latched   = r_latched;
    assign o_sts.last      = r_last;
    assign o_sts.sep       = r_sep;
    assign o_sts.in_num    = r_in_num;
    assign o_sts.zero_need = r_at_start || (r_prev == C_LPAR);
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.top_lp    = (r_top == C_LPAR);
    assign o_sts.top_pm    = (r_top == C_PLUS) || (r_top == C_MINUS);
    assign o_sts.name_hit  = (code != C_NUL);
    assign o_sts.put_rdy   = !room || !r_hold_v || out_free;
    assign o_sts.out_free  = out_free;
    assign o_sts.hold_v    = r_hold_v;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Operator stack storage and the registered read of the entry under the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[wr_addr] <= push_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char <= i_data.in_char;
            r_last <= i_data.in_last;
        end
        if (i_cmd.push) begin
            r_top <= push_data;
        end else if (i_cmd.pop || i_cmd.drop) begin
            r_top <= r_rd;
        end
        if (i_cmd.put && room) begin
            r_hold <= put_data;
        end
        if (i_cmd.err_out) begin
            r_out <= '{out_char: C_NUL, out_last: 1'b1, error_code: err};
        end else if (i_cmd.deliver && (r_hold_v || r_last)) begin
            r_out <= '{out_char: r_hold_v ? r_hold : C_NUL, out_last: r_last,
                       error_code: E_OK};
        end else if (i_cmd.put && room && r_hold_v) begin
            r_out <= '{out_char: r_hold, out_last: 1'b0, error_code: E_OK};
        end
    end

    // Control and converter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_lp       <= '0;
            r_prev     <= C_NUL;
            r_at_start <= 1'b1;
            r_in_num   <= 1'b0;
            r_nb       <= '0;
            r_nlen     <= '0;
            r_latched  <= 1'b0;
            r_sep      <= 1'b0;
            r_hold_v   <= 1'b0;
            r_ocnt     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.capture) r_ocnt <= '0;
            if (i_cmd.push) begin
                r_cnt <= r_cnt + CW'(1);
                if (push_data == C_LPAR) r_lp <= r_lp + CW'(1);
            end
            if (i_cmd.pop) r_cnt <= r_cnt - CW'(1);
            if (i_cmd.drop) begin
                r_cnt <= r_cnt - CW'(1);
                r_lp  <= r_lp - CW'(1);
            end
            if (i_cmd.name_step) begin
                r_nb   <= n_nb;
                r_nlen <= n_nlen;
            end
            if (i_cmd.name_clear) begin
                r_nb   <= '0;
                r_nlen <= '0;
            end
            if (i_cmd.in_num_set) r_in_num <= 1'b1;
            if (i_cmd.in_num_clr) r_in_num <= 1'b0;
            if (i_cmd.set_sep) r_sep <= 1'b1;
            if (i_cmd.commit) begin
                r_prev     <= r_char;
                r_at_start <= 1'b0;
            end
            if (i_cmd.latch) r_latched <= 1'b1;

            // Output register: a written character moves the held one out.
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cmd.put && room) begin
                r_ocnt   <= r_ocnt + 6'd1;
                r_hold_v <= 1'b1;
                if (r_hold_v) r_ovalid <= 1'b1;
            end
            if (i_cmd.deliver) begin
                r_hold_v <= 1'b0;
                if (r_hold_v || r_last) r_ovalid <= 1'b1;
            end
            if (i_cmd.err_out) r_ovalid <= 1'b1;

            if (i_cmd.clear_all) begin
                r_cnt      <= '0;
                r_lp       <= '0;
                r_prev     <= C_NUL;
                r_at_start <= 1'b1;
                r_in_num   <= 1'b0;
                r_nb       <= '0;
                r_nlen     <= '0;
                r_latched  <= 1'b0;
                r_sep      <= 1'b0;
            end
        end
    end

endmodule

// File: sv/i2p_ctrl.sv
`timescale 1ns / 1ps
module i2p_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  i2p_pkg::t_sts i_sts,
    output i2p_pkg::t_cmd o_cmd
);
    import i2p_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ERR, S_CHK, S_TOK_SP, S_TOK_CH, S_DROP, S_PUSH, S_END, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        M_RP, M_PM, M_MD, M_FL
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_src   r_src, n_src;
    logic   need_sp;

    assign o_stall = (r_state != S_IDLE);
    assign need_sp = i_sts.sep && !(r_src == PS_CHAR && i_sts.in_num);

    // Next state and the command for the datapath.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_src   = r_src;
        o_cmd   = '0;
        o_cmd.put_sel = PS_SPACE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.latched) begin
                    o_cmd.clear_all = i_sts.last;
                    n_state = S_IDLE;
                end else if (i_sts.err != E_OK) begin
                    n_state = S_ERR;
                end else begin
                    case (i_sts.cls)
                        CL_DIGIT: begin
                            o_cmd.name_clear = 1'b1;
                            n_src   = PS_CHAR;
                            n_state = S_TOK_SP;
                        end
                        CL_LETTER: begin
                            o_cmd.in_num_clr = 1'b1;
                            if (i_sts.name_hit) begin
                                o_cmd.push       = 1'b1;
                                o_cmd.push_code  = 1'b1;
                                o_cmd.name_clear = 1'b1;
                            end else begin
                                o_cmd.name_step = 1'b1;
                            end
                            n_state = S_END;
                        end
                        CL_PUSH: begin
                            o_cmd.in_num_clr = 1'b1;
                            o_cmd.name_clear = 1'b1;
                            o_cmd.push       = 1'b1;
                            n_state = S_END;
                        end
                        CL_RPAR, CL_PM, CL_MD: begin
                            o_cmd.in_num_clr = 1'b1;
                            o_cmd.name_clear = 1'b1;
                            n_mode = (i_sts.cls == CL_RPAR) ? M_RP :
                                     (i_sts.cls == CL_PM) ? M_PM : M_MD;
                            n_state = S_CHK;
                        end
                        default: begin
                            o_cmd.in_num_clr = 1'b1;
                            o_cmd.name_clear = 1'b1;
                            n_state = S_END;
                        end
                    endcase
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.err_out   = 1'b1;
                    o_cmd.latch     = 1'b1;
                    o_cmd.clear_all = i_sts.last;
                    n_state = S_IDLE;
                end
            end
            // Pop loop: decide whether the top leaves the stack.
            S_CHK: begin
                n_src = PS_TOP;
                case (r_mode)
                    M_RP: n_state = i_sts.top_lp ? S_DROP : S_TOK_SP;
                    M_PM: begin
                        if (i_sts.cnt_zero || i_sts.top_lp) begin
                            n_src   = PS_ZERO;
                            n_state = i_sts.zero_need ? S_TOK_SP : S_PUSH;
                        end else begin
                            n_state = S_TOK_SP;
                        end
                    end
                    M_MD: begin
                        n_state = (i_sts.cnt_zero || i_sts.top_lp || i_sts.top_pm) ?
                                  S_PUSH : S_TOK_SP;
                    end
                    default: begin
                        if (i_sts.cnt_zero) n_state = S_FIN;
                        else if (i_sts.top_lp) n_state = S_DROP;
                        else n_state = S_TOK_SP;
                    end
                endcase
            end
            S_TOK_SP: begin
                if (!need_sp) begin
                    n_state = S_TOK_CH;
                end else if (i_sts.put_rdy) begin
                    o_cmd.put = 1'b1;
                    n_state = S_TOK_CH;
                end
            end
            S_TOK_CH: begin
                if (i_sts.put_rdy) begin
                    o_cmd.put     = 1'b1;
                    o_cmd.put_sel = r_src;
                    o_cmd.set_sep = 1'b1;
                    case (r_src)
                        PS_CHAR: begin
                            o_cmd.in_num_set = 1'b1;
                            n_state = S_END;
                        end
                        PS_TOP: begin
                            o_cmd.pop = 1'b1;
                            n_state = S_CHK;
                        end
                        default: n_state = S_PUSH;
                    endcase
                end
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                n_state = (r_mode == M_FL) ? S_CHK : S_END;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = S_END;
            end
            S_END: begin
                o_cmd.commit = 1'b1;
                if (i_sts.last) begin
                    n_mode  = M_FL;
                    n_state = S_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!(i_sts.hold_v || i_sts.last) || i_sts.out_free) begin
                    o_cmd.deliver   = 1'b1;
                    o_cmd.clear_all = i_sts.last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_RP;
            r_src   <= PS_CHAR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_src   <= n_src;
        end
    end

endmodule

// File: sv/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// Each character walks the control states; every operator popped from the stack adds a pass through
// S_TOK_SP, S_TOK_CH and S_CHK, and every dropped '(' adds a pass through S_DROP.
// Throughput: one character at a time; the pop loop of the operator stack sets the rate.
// Results leave through a one-entry output register with one more character held back.
// Reset: synchronous, active low; clears the stack count and all converter state.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  i2p_pkg::t_in_item  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output i2p_pkg::t_out_item o_data,
    input  logic               i_stall
);
    import i2p_pkg::*;

    t_cmd cmd;
    t_sts sts;

    i2p_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    i2p_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// File: sv/i2p_checker.sv
`timescale 1ns / 1ps
module i2p_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input i2p_pkg::t_in_item  i_data,
    input logic               o_stall,
    input logic               o_valid,
    input i2p_pkg::t_out_item o_data,
    input logic               i_stall
);
    import i2p_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // A stalled request holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("stalled request changed");

    // Reset empties the output.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An error result is the final one and carries no character.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error_code != E_OK |-> o_data.out_last && o_data.out_char == C_NUL)
        else $error("malformed error result");

    // A taken request occupies the converter in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while not busy afterwards");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import i2p_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall;

    infix_to_postfix_converter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Converter state mirrored by the predictor.
    logic [7:0]  op_stack [0:15];
    int          op_count;
    logic [7:0]  prev_char;
    bit          expr_start;
    bit          num_open;
    logic [47:0] name_buf;
    int          name_len;
    bit          err_held;
    bit          space_due;

    logic [7:0]  step_chars [$];
    t_out_item   pending_results [$];

    int          fail_count;
    int          result_count;
    int          request_count;
    int          send_idle_pct;
    int          stall_pct;

    // Clears the mirrored converter state, as after reset or a final character.
    function automatic void clear_converter();
        op_count   = 0;
        prev_char  = C_NUL;
        expr_start = 1;
        num_open   = 0;
        name_buf   = '0;
        name_len   = 0;
        err_held   = 0;
        space_due  = 0;
    endfunction

    function automatic void put_char(logic [7:0] c);
        if (step_chars.size() < MAX_RESULTS) step_chars.push_back(c);
    endfunction

    function automatic void emit_token(logic [7:0] c);
        if (space_due) put_char(C_SPACE);
        put_char(c);
        space_due = 1;
    endfunction

    function automatic bit push_op(logic [7:0] c);
        if (op_count >= 16) return 0;
        op_stack[op_count] = c;
        op_count++;
        return 1;
    endfunction

    function automatic void pop_token();
        op_count--;
        emit_token(op_stack[op_count]);
    endfunction

    function automatic logic [7:0] name_code();
        if (name_len >= 6) begin
            if (name_buf == N_ARCSIN) return K_ARCSIN;
            if (name_buf == N_ARCCOS) return K_ARCCOS;
            if (name_buf == N_ARCTAN) return K_ARCTAN;
            if (name_buf == N_SQUARE) return K_SQUARE;
        end
        if (name_len >= 3) begin
            if (name_buf[23:0] == N_SIN) return K_SIN;
            if (name_buf[23:0] == N_COS) return K_COS;
            if (name_buf[23:0] == N_TAN) return K_TAN;
        end
        return C_NUL;
    endfunction

    // Handles one character and returns its error code.
    function automatic logic [1:0] convert_char(logic [7:0] c);
        logic [1:0] err;
        logic [7:0] code;
        err = E_OK;
        if ((c >= C_ZERO && c <= C_NINE) || c == C_DOT) begin
            if (!num_open && space_due) put_char(C_SPACE);
            put_char(c);
            num_open  = 1;
            space_due = 1;
            name_buf  = '0;
            name_len  = 0;
            return E_OK;
        end
        num_open = 0;
        if (c >= C_LOW_A && c <= C_LOW_Z) begin
            name_buf = {name_buf[39:0], c};
            if (name_len < 6) name_len++;
            code = name_code();
            if (code != C_NUL) begin
                if (!push_op(code)) err = E_OVERFLOW;
                name_buf = '0;
                name_len = 0;
            end
            return err;
        end
        name_buf = '0;
        name_len = 0;
        case (c)
            C_LPAR, C_CARET: begin
                if (!push_op(c)) err = E_OVERFLOW;
            end
            C_RPAR: begin
                if (prev_char == C_LPAR) begin
                    err = E_EMPTY;
                end else begin
                    forever begin
                        if (op_count == 0) begin
                            err = E_UNMATCH;
                            break;
                        end
                        if (op_stack[op_count-1] == C_LPAR) begin
                            op_count--;
                            break;
                        end
                        pop_token();
                    end
                end
            end
            C_PLUS, C_MINUS: begin
                while (op_count > 0 && op_stack[op_count-1] != C_LPAR) pop_token();
                if (expr_start || prev_char == C_LPAR) emit_token(C_ZERO);
                if (!push_op(c)) err = E_OVERFLOW;
            end
            C_STAR, C_SLASH, C_PCT: begin
                while (op_count > 0 && op_stack[op_count-1] != C_LPAR &&
                       op_stack[op_count-1] != C_PLUS &&
                       op_stack[op_count-1] != C_MINUS) pop_token();
                if (!push_op(c)) err = E_OVERFLOW;
            end
            default: ;
        endcase
        return err;
    endfunction

    // Predicts the postfix characters caused by one request.
    function automatic void predict_postfix(t_in_item req);
        logic [1:0] err;
        bit         was_held;
        t_out_item  r;
        err = E_OK;
        was_held = err_held;
        step_chars.delete();
        if (!was_held) begin
            err = convert_char(req.in_char);
            prev_char  = req.in_char;
            expr_start = 0;
        end
        if (err != E_OK) begin
            r.out_char = C_NUL;
            r.out_last = 1'b1;
            r.error_code = err;
            pending_results.push_back(r);
            err_held = 1;
            if (req.in_last) clear_converter();
            return;
        end
        if (was_held) begin
            if (req.in_last) clear_converter();
            return;
        end
        if (req.in_last) begin
            while (op_count > 0) begin
                if (op_stack[op_count-1] == C_LPAR) op_count--;
                else pop_token();
            end
            if (step_chars.size() == 0) put_char(C_NUL);
        end
        foreach (step_chars[k]) begin
            r.out_char = step_chars[k];
            r.out_last = req.in_last && (k == step_chars.size() - 1);
            r.error_code = E_OK;
            pending_results.push_back(r);
        end
        if (req.in_last) clear_converter();
    endfunction

    // Sends one request, holding it until accepted.
    task automatic send_char(logic [7:0] c, bit last);
        t_in_item req;
        req.in_char = c;
        req.in_last = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_postfix(req);
        request_count++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
    endtask

    // Waits for every expected result, then lets the pipeline drain.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("unexpected result char %h", o_data.out_char);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.out_char !== want.out_char) begin
                    $error("out_char expected %h actual %h", want.out_char, o_data.out_char);
                    fail_count++;
                end
                if (o_data.out_last !== want.out_last) begin
                    $error("out_last expected %b actual %b", want.out_last, o_data.out_last);
                    fail_count++;
                end
                if (o_data.error_code !== want.error_code) begin
                    $error("error_code expected %d actual %d",
                           want.error_code, o_data.error_code);
                    fail_count++;
                end
            end
        end
    end

    // Directed expressions covering operators, names and error cases.
    task automatic test_directed();
        send_text("12+3.5*(4-1)^2");
        send_text("-7%2/9");
        send_text("(-sin3)+arcsin2*square1");
        send_text("()");
        send_text("2)");
        send_text("cos(tan1)+arccos1-arctan2");
        send_char(8'hFF, 1'b0);
        send_char(C_NUL, 1'b1);
        send_text("((((((((((((((((((");
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        pool = "0123456789.+-*/%^()()sincostanarcsquare ";
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // Random expressions: mostly well-formed tokens, with some noise.
    task automatic test_random(int count);
        int n;
        string names [7];
        string t;
        names = '{"sin", "cos", "tan", "arcsin", "arccos", "arctan", "square"};
        n = 0;
        while (n < count) begin
            int len;
            len = $urandom_range(2, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(3) == 0) begin
                    t = names[$urandom_range(6)];
                    for (int j = 0; j < t.len(); j++) send_char(t[j], 1'b0);
                    n += t.len();
                end else begin
                    send_char(pick_char(), 1'b0);
                    n++;
                end
            end
            send_char(pick_char(), 1'b1);
            n++;
        end
    endtask

    // Sender waits for the converter to finish before the next expression.
    task automatic test_pause();
        send_text("9^8^7");
        wait_drained();
        send_text("1+2");
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        fail_count = 0;
        result_count = 0;
        request_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        clear_converter();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause();
        test_random(75);
        send_idle_pct = 69;
        test_random(75);
        send_idle_pct = 0;
        stall_pct = 69;
        test_random(75);
        send_idle_pct = 16;
        stall_pct = 16;
        test_random(75);
        wait_drained();

        $display("Sent %0d characters of infix text and checked %0d postfix results,",
                 request_count, result_count);
        $display("across operators, function names, errors and idle/stall phases.");
        if (fail_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: infix_to_postfix_converter.f
sv/i2p_pkg.sv
sv/i2p_dpath.sv
sv/i2p_ctrl.sv
sv/infix_to_postfix_converter.sv
sv/i2p_checker.sv
tb/tb.sv
